[rtl/core/drcs_pkg.sv]
package drcs_pkg;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_INS_WAIT,
		S_INS_LINK,
		S_PICK_FIX
	} state_t;

	// result status codes
	typedef enum logic [2:0] {
		STAT_ACCEPTED = 3'd0,
		STAT_INVALID  = 3'd1,
		STAT_FULL     = 3'd2,
		STAT_GRANTED  = 3'd3,
		STAT_EMPTY    = 3'd4
	} status_t;

	// command codes on func
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_PICK   = 1'b1;

	// configuration register indexes
	localparam logic CFG_TRACK_LIMIT       = 1'b0;
	localparam logic CFG_SECTORS_PER_TRACK = 1'b1;

	// configuration reset values
	localparam logic [15:0] TRACK_LIMIT_RST = 16'd16;
	localparam logic [7:0]  SECTORS_RST     = 8'd16;

endpackage

[rtl/core/drcs_ram.sv]
module drcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/disk_request_clook_scheduler.sv]
// C-LOOK scheduler for the pending requests of one disk unit.
// Commands: a word is taken at a clock edge with start high and busy low.
// func selects insert (request fields) or pick (head_track). Each command
// gives exactly one result word, shown for one cycle with done high.
// Insert links the request into a track-sorted list (ties in arrival order);
// pick grants the oldest request with the lowest track at or above the head,
// else wraps to the lowest track. grant_ fields are zero unless granted.
// A rejected insert or an empty pick reports in the cycle after start is taken.
// Otherwise the list in the slot RAM is walked one entry per cycle (the RAM
// read port sets this); an insert also scans the valid bits one per cycle for
// the lowest free slot, overlapped with the walk. A pick then unlinks its
// target and reports; an insert writes its record once walk and scan are
// through, then rewrites the link of any entry it follows, and reports.
// busy is high outside S_IDLE. Configuration: cfg_we writes cfg_data to
// register cfg_index (0 track limit, 1 sectors per track); the user writes
// it only while the block is idle, which the block itself does not enforce.
// Reset: list empty, registers back to 16; the RAM is not cleared.
// The receiver cannot stall: done is a one cycle strobe.
module disk_request_clook_scheduler #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TRACK_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [7:0]  req_tag,
	input  logic [15:0] req_track,
	input  logic [7:0]  req_first_sector,
	input  logic [9:0]  req_sector_count,
	input  logic        req_is_write,
	input  logic [15:0] head_track,
	output logic        done,
	output logic [2:0]  status,
	output logic [7:0]  grant_tag,
	output logic [15:0] grant_track,
	output logic [7:0]  grant_first_sector,
	output logic [9:0]  grant_sector_count,
	output logic        grant_is_write,
	output logic [4:0]  occupancy
);

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int LW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [LW-1:0] NULL_LINK = LW'(QUEUE_DEPTH);

	typedef struct packed {
		logic [7:0]            tag;
		logic [TRACK_BITS-1:0] track;
		logic [7:0]            first;
		logic [9:0]            count;
		logic                  wr;
		logic [LW-1:0]         link;
	} rec_t;

	localparam int RW = $bits(rec_t);

	drcs_pkg::state_t  state_q, state_d;
	drcs_pkg::status_t status_q;

	logic [15:0]           track_limit_q;
	logic [7:0]            spt_q;
	logic [QUEUE_DEPTH-1:0] valid_q;
	logic [LW-1:0]         head_q;
	logic [LW-1:0]         count_q;
	logic                  done_q;
	logic [IW-1:0]         find_idx_q;
	logic                  find_done_q;

	logic                  func_q;
	logic [7:0]            tag_q;
	logic [TRACK_BITS-1:0] trk_q;
	logic [7:0]            first_q;
	logic [9:0]            scount_q;
	logic                  wr_q;
	logic [LW-1:0]         cur_q;
	logic [LW-1:0]         prev_q;
	rec_t                  prev_rec_q;
	rec_t                  cur_rec_q;
	rec_t                  head_rec_q;
	logic [7:0]            g_tag_q;
	logic [15:0]           g_track_q;
	logic [7:0]            g_first_q;
	logic [9:0]            g_count_q;
	logic                  g_wr_q;

	logic                  accept;
	logic [TRACK_BITS+15:0] req_ext, hd_ext, trk_ext, lim_ext, gtrk_ext;
	logic [TRACK_BITS-1:0] trk_in, hd_in;
	logic                  bad, full, empty, head_is_node, link_is_node, walk_cont;
	logic                  prev_is_node;
	logic                  tgt_wrap, tgt_has_prev;
	logic [LW-1:0]         tgt_idx;
	rec_t                  tgt_rec, rd, new_rec, wdata_rec;
	logic [RW-1:0]         ram_rdata;
	logic                  ram_we;
	logic [IW-1:0]         ram_waddr, ram_raddr;
	logic [LW+4:0]         cnt_ext;

	// slot records: request fields and list link
	drcs_ram #(
		.WIDTH(RW),
		.DEPTH(QUEUE_DEPTH)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wdata_rec),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd = rec_t'(ram_rdata);

	// input decode and range checks
	assign accept   = start && !busy;
	assign req_ext  = {{TRACK_BITS{1'b0}}, req_track};
	assign hd_ext   = {{TRACK_BITS{1'b0}}, head_track};
	assign trk_in   = req_ext[TRACK_BITS-1:0];
	assign hd_in    = hd_ext[TRACK_BITS-1:0];
	assign trk_ext  = {16'b0, trk_in};
	assign lim_ext  = {{TRACK_BITS{1'b0}}, track_limit_q};
	assign bad      = (trk_ext >= lim_ext) || (req_first_sector >= spt_q);
	assign full     = (count_q == NULL_LINK);
	assign empty    = (count_q == '0);
	assign head_is_node = (head_q < NULL_LINK);

	// list walk compare on the record just read
	assign link_is_node = (rd.link < NULL_LINK);
	assign walk_cont    = (func_q == drcs_pkg::FUNC_INSERT) ? (rd.track <= trk_q)
	                                                        : (rd.track < trk_q);
	assign prev_is_node = (prev_q < NULL_LINK);

	// pick target, wrapping to the list head when nothing is at or above
	assign tgt_wrap     = !(cur_q < NULL_LINK);
	assign tgt_idx      = tgt_wrap ? head_q : cur_q;
	assign tgt_rec      = tgt_wrap ? head_rec_q : cur_rec_q;
	assign tgt_has_prev = !tgt_wrap && prev_is_node;

	assign new_rec = '{tag: tag_q, track: trk_q, first: first_q, count: scount_q,
	                   wr: wr_q, link: cur_q};

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= drcs_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory port control
	always_comb begin
		state_d   = state_q;
		ram_raddr = head_q[IW-1:0];
		ram_we    = 1'b0;
		ram_waddr = find_idx_q;
		wdata_rec = new_rec;
		case (state_q)
			drcs_pkg::S_IDLE: begin
				if (accept) begin
					if (func == drcs_pkg::FUNC_INSERT) begin
						if (!(bad || full)) begin
							state_d = head_is_node ? drcs_pkg::S_WALK : drcs_pkg::S_INS_WAIT;
						end
					end else if (!empty) begin
						state_d = drcs_pkg::S_WALK;
					end
				end
			end
			drcs_pkg::S_WALK: begin
				if (walk_cont && link_is_node) begin
					ram_raddr = rd.link[IW-1:0];
				end else begin
					state_d = (func_q == drcs_pkg::FUNC_INSERT) ? drcs_pkg::S_INS_WAIT
					                                             : drcs_pkg::S_PICK_FIX;
				end
			end
			drcs_pkg::S_INS_WAIT: begin
				if (find_done_q) begin
					ram_we  = 1'b1;
					state_d = prev_is_node ? drcs_pkg::S_INS_LINK : drcs_pkg::S_IDLE;
				end
			end
			drcs_pkg::S_INS_LINK: begin
				ram_we         = 1'b1;
				ram_waddr      = prev_q[IW-1:0];
				wdata_rec      = prev_rec_q;
				wdata_rec.link = LW'(find_idx_q);
				state_d        = drcs_pkg::S_IDLE;
			end
			drcs_pkg::S_PICK_FIX: begin
				ram_we         = tgt_has_prev;
				ram_waddr      = prev_q[IW-1:0];
				wdata_rec      = prev_rec_q;
				wdata_rec.link = tgt_rec.link;
				state_d        = drcs_pkg::S_IDLE;
			end
			default: begin
				state_d = drcs_pkg::S_IDLE;
			end
		endcase
	end

	// control registers: config, valid bits, list head, count, free slot scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_limit_q <= drcs_pkg::TRACK_LIMIT_RST;
			spt_q         <= drcs_pkg::SECTORS_RST;
			valid_q       <= '0;
			head_q        <= NULL_LINK;
			count_q       <= '0;
			done_q        <= 1'b0;
			find_idx_q    <= '0;
			find_done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					drcs_pkg::CFG_TRACK_LIMIT:       track_limit_q <= cfg_data;
					drcs_pkg::CFG_SECTORS_PER_TRACK: spt_q         <= cfg_data[7:0];
					default: ;
				endcase
			end
			// lowest free slot, one valid bit per cycle
			if (func_q == drcs_pkg::FUNC_INSERT && !find_done_q &&
			    (state_q == drcs_pkg::S_WALK || state_q == drcs_pkg::S_INS_WAIT)) begin
				if (valid_q[find_idx_q]) begin
					find_idx_q <= find_idx_q + 1'b1;
				end else begin
					find_done_q <= 1'b1;
				end
			end
			case (state_q)
				drcs_pkg::S_IDLE: begin
					if (accept) begin
						find_idx_q  <= '0;
						find_done_q <= 1'b0;
						if (func == drcs_pkg::FUNC_INSERT) begin
							done_q <= bad || full;
						end else begin
							done_q <= empty;
						end
					end
				end
				drcs_pkg::S_INS_WAIT: begin
					if (find_done_q) begin
						valid_q[find_idx_q] <= 1'b1;
						count_q             <= count_q + 1'b1;
						if (!prev_is_node) begin
							head_q <= LW'(find_idx_q);
							done_q <= 1'b1;
						end
					end
				end
				drcs_pkg::S_INS_LINK: begin
					done_q <= 1'b1;
				end
				drcs_pkg::S_PICK_FIX: begin
					valid_q[tgt_idx[IW-1:0]] <= 1'b0;
					count_q                  <= count_q - 1'b1;
					if (!tgt_has_prev) begin
						head_q <= tgt_rec.link;
					end
					done_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign gtrk_ext = {16'b0, tgt_rec.track};

	// command word, walk pointers and result word
	always_ff @(posedge clk) begin
		case (state_q)
			drcs_pkg::S_IDLE: begin
				if (accept) begin
					func_q   <= func;
					tag_q    <= req_tag;
					trk_q    <= (func == drcs_pkg::FUNC_INSERT) ? trk_in : hd_in;
					first_q  <= req_first_sector;
					scount_q <= req_sector_count;
					wr_q     <= req_is_write;
					cur_q    <= head_q;
					prev_q   <= NULL_LINK;
					if (func == drcs_pkg::FUNC_INSERT) begin
						status_q <= bad ? drcs_pkg::STAT_INVALID : drcs_pkg::STAT_FULL;
						if (!(bad || full) && !head_is_node) begin
							cur_q <= NULL_LINK;
						end
					end else begin
						status_q <= drcs_pkg::STAT_EMPTY;
					end
					g_tag_q   <= '0;
					g_track_q <= '0;
					g_first_q <= '0;
					g_count_q <= '0;
					g_wr_q    <= 1'b0;
				end
			end
			drcs_pkg::S_WALK: begin
				if (!prev_is_node) begin
					head_rec_q <= rd;
				end
				if (walk_cont) begin
					prev_q     <= cur_q;
					prev_rec_q <= rd;
					cur_q      <= link_is_node ? rd.link : NULL_LINK;
				end else begin
					cur_rec_q <= rd;
				end
			end
			drcs_pkg::S_INS_WAIT: begin
				status_q <= drcs_pkg::STAT_ACCEPTED;
			end
			drcs_pkg::S_PICK_FIX: begin
				status_q  <= drcs_pkg::STAT_GRANTED;
				g_tag_q   <= tgt_rec.tag;
				g_track_q <= gtrk_ext[15:0];
				g_first_q <= tgt_rec.first;
				g_count_q <= tgt_rec.count;
				g_wr_q    <= tgt_rec.wr;
			end
			default: ;
		endcase
	end

	// outputs
	assign busy               = (state_q != drcs_pkg::S_IDLE);
	assign done               = done_q;
	assign status             = status_q;
	assign grant_tag          = g_tag_q;
	assign grant_track        = g_track_q;
	assign grant_first_sector = g_first_q;
	assign grant_sector_count = g_count_q;
	assign grant_is_write     = g_wr_q;
	assign cnt_ext            = {5'b0, count_q};
	assign occupancy          = cnt_ext[4:0];

endmodule

[test/disk_request_clook_scheduler_tb.sv]
module disk_request_clook_scheduler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;
	localparam int SETTLE = DEPTH + 4;
	localparam int CYCLE_LIMIT = 1000000;

	typedef enum logic [1:0] {
		STEP_WORD,
		STEP_CFG,
		STEP_SYNC
	} step_kind_t;

	// one entry of the stimulus list: a command word, a register write or a sync point
	typedef struct {
		step_kind_t  kind;
		logic        fn;
		logic [7:0]  tag;
		logic [15:0] trk;
		logic [7:0]  first;
		logic [9:0]  count;
		logic        wr;
		logic [15:0] head;
		int          gap;
		logic        reg_index;
		logic [15:0] reg_value;
	} step_t;

	typedef struct {
		drcs_pkg::status_t status;
		logic [7:0]  tag;
		logic [15:0] trk;
		logic [7:0]  first;
		logic [9:0]  count;
		logic        wr;
		logic [4:0]  occ;
	} outcome_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = drcs_pkg::CFG_TRACK_LIMIT;
	logic [15:0] cfg_data = '0;
	logic        start = 1'b0;
	logic        busy;
	logic        func = drcs_pkg::FUNC_INSERT;
	logic [7:0]  req_tag = '0;
	logic [15:0] req_track = '0;
	logic [7:0]  req_first_sector = '0;
	logic [9:0]  req_sector_count = '0;
	logic        req_is_write = 1'b0;
	logic [15:0] head_track = '0;
	logic        done;
	logic [2:0]  status;
	logic [7:0]  grant_tag;
	logic [15:0] grant_track;
	logic [7:0]  grant_first_sector;
	logic [9:0]  grant_sector_count;
	logic        grant_is_write;
	logic [4:0]  occupancy;

	step_t    pending_steps[$];
	outcome_t results_due[$];
	int       error_count = 0;
	int       cycle_count = 0;

	// mirror of the request table, its sorted list and the registers
	logic        bank_valid [DEPTH];
	logic [7:0]  bank_tag [DEPTH];
	logic [15:0] bank_track [DEPTH];
	logic [7:0]  bank_first [DEPTH];
	logic [9:0]  bank_count [DEPTH];
	logic        bank_wr [DEPTH];
	int          bank_link [DEPTH];
	int          list_first = DEPTH;
	int          held = 0;
	logic [15:0] track_limit_now = drcs_pkg::TRACK_LIMIT_RST;
	logic [7:0]  sectors_now = drcs_pkg::SECTORS_RST;

	// generator side view of the registers
	int          gen_limit = int'(drcs_pkg::TRACK_LIMIT_RST);
	int          gen_sectors = int'(drcs_pkg::SECTORS_RST);
	logic [15:0] recent_track = '0;
	logic        no_gaps = 1'b0;

	// driver bookkeeping
	step_t       on_port;
	step_t       taken;
	logic        start_next;
	logic        write_next;
	int          hold_off = 0;
	int          quiet_cycles = 0;

	disk_request_clook_scheduler #(
		.QUEUE_DEPTH(DEPTH),
		.TRACK_BITS(16)
	) dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic flag_error(string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			flag_error($sformatf("%s is 0x%0h, want 0x%0h", name, got, want));
	endtask

	// work out the result word of one command and update the table mirror
	function automatic void schedule_word(step_t w);
		outcome_t r;
		int       slot;
		int       prev;
		int       walk;
		int       i;
		r.status = drcs_pkg::STAT_ACCEPTED;
		r.tag = '0;
		r.trk = '0;
		r.first = '0;
		r.count = '0;
		r.wr = 1'b0;
		prev = DEPTH;
		walk = list_first;
		slot = DEPTH;
		if (w.fn == drcs_pkg::FUNC_INSERT) begin
			// range checks win over the full check
			if (w.trk >= track_limit_now || w.first >= sectors_now) begin
				r.status = drcs_pkg::STAT_INVALID;
			end else begin
				// lowest numbered free slot
				for (i = DEPTH - 1; i >= 0; i--)
					if (!bank_valid[i])
						slot = i;
				if (held >= DEPTH || slot == DEPTH) begin
					r.status = drcs_pkg::STAT_FULL;
				end else begin
					bank_valid[slot] = 1'b1;
					bank_tag[slot] = w.tag;
					bank_track[slot] = w.trk;
					bank_first[slot] = w.first;
					bank_count[slot] = w.count;
					bank_wr[slot] = w.wr;
					// pass every entry at or below the new track, ties keep arrival order
					while (walk != DEPTH && bank_track[walk] <= w.trk) begin
						prev = walk;
						walk = bank_link[walk];
					end
					bank_link[slot] = walk;
					if (prev == DEPTH)
						list_first = slot;
					else
						bank_link[prev] = slot;
					held++;
				end
			end
		end else if (list_first == DEPTH || held == 0) begin
			r.status = drcs_pkg::STAT_EMPTY;
		end else begin
			// first entry at or above the head, else wrap to the lowest track
			while (walk != DEPTH && bank_track[walk] < w.head) begin
				prev = walk;
				walk = bank_link[walk];
			end
			if (walk == DEPTH) begin
				walk = list_first;
				prev = DEPTH;
			end
			if (prev == DEPTH)
				list_first = bank_link[walk];
			else
				bank_link[prev] = bank_link[walk];
			bank_valid[walk] = 1'b0;
			held--;
			r.status = drcs_pkg::STAT_GRANTED;
			r.tag = bank_tag[walk];
			r.trk = bank_track[walk];
			r.first = bank_first[walk];
			r.count = bank_count[walk];
			r.wr = bank_wr[walk];
		end
		r.occ = 5'(held);
		results_due.push_back(r);
	endfunction

	function automatic int draw_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (no_gaps || roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void add_word(logic fn, logic [7:0] tag, logic [15:0] trk,
			logic [7:0] first, logic [9:0] count, logic wr, logic [15:0] head);
		step_t s;
		s.kind = STEP_WORD;
		s.fn = fn;
		s.tag = tag;
		s.trk = trk;
		s.first = first;
		s.count = count;
		s.wr = wr;
		s.head = head;
		s.gap = draw_gap();
		s.reg_index = drcs_pkg::CFG_TRACK_LIMIT;
		s.reg_value = '0;
		pending_steps.push_back(s);
	endfunction

	function automatic void add_sync();
		step_t s;
		s.kind = STEP_SYNC;
		s.fn = drcs_pkg::FUNC_INSERT;
		s.tag = '0;
		s.trk = '0;
		s.first = '0;
		s.count = '0;
		s.wr = 1'b0;
		s.head = '0;
		s.gap = 0;
		s.reg_index = drcs_pkg::CFG_TRACK_LIMIT;
		s.reg_value = '0;
		pending_steps.push_back(s);
	endfunction

	// only ever queued right behind a sync point or another register write
	function automatic void add_config(logic idx, logic [15:0] value);
		step_t s;
		s.kind = STEP_CFG;
		s.fn = drcs_pkg::FUNC_INSERT;
		s.tag = '0;
		s.trk = '0;
		s.first = '0;
		s.count = '0;
		s.wr = 1'b0;
		s.head = '0;
		s.gap = 0;
		s.reg_index = idx;
		s.reg_value = value;
		pending_steps.push_back(s);
		if (idx == drcs_pkg::CFG_TRACK_LIMIT)
			gen_limit = int'(value);
		else
			gen_sectors = int'(value[7:0]);
	endfunction

	function automatic void add_random_insert();
		logic [15:0] trk;
		logic [7:0]  first;
		int          roll;
		roll = $urandom_range(0, 99);
		if (roll < 10 || gen_limit == 0)
			trk = 16'($urandom);
		else if (roll < 40)
			trk = recent_track;
		else
			trk = 16'($urandom_range(0, gen_limit - 1));
		if ($urandom_range(0, 99) < 8 || gen_sectors == 0)
			first = 8'($urandom);
		else
			first = 8'($urandom_range(0, gen_sectors - 1));
		if (int'(trk) < gen_limit)
			recent_track = trk;
		add_word(drcs_pkg::FUNC_INSERT, 8'($urandom), trk, first, 10'($urandom),
			1'($urandom), 16'($urandom));
	endfunction

	function automatic void add_random_pick();
		logic [15:0] head;
		int          roll;
		roll = $urandom_range(0, 99);
		if (roll < 20)
			head = 16'($urandom);
		else if (roll < 50)
			head = recent_track;
		else
			head = 16'($urandom_range(0, gen_limit));
		add_word(drcs_pkg::FUNC_PICK, 8'($urandom), 16'($urandom), 8'($urandom),
			10'($urandom), 1'($urandom), head);
	endfunction

	// one register setting followed by runs of fill, drain and mixed traffic
	function automatic void add_phase(int track_lim, int sector_lim, int words);
		int made;
		int run;
		int mode;
		int share;
		int i;
		add_sync();
		add_config(drcs_pkg::CFG_TRACK_LIMIT, 16'(track_lim));
		add_config(drcs_pkg::CFG_SECTORS_PER_TRACK, 16'(sector_lim));
		made = 0;
		while (made < words) begin
			mode = $urandom_range(0, 3);
			run = $urandom_range(8, 40);
			share = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
			no_gaps = (mode == 3);
			if ($urandom_range(0, 11) == 0)
				add_sync();
			for (i = 0; i < run; i++) begin
				if ($urandom_range(0, 99) < share)
					add_random_insert();
				else
					add_random_pick();
			end
			made += run;
		end
		no_gaps = 1'b0;
	endfunction

	// stimulus, reset and end of run
	initial begin
		foreach (bank_valid[i])
			bank_valid[i] = 1'b0;

		// directed words under the reset register values
		add_word(drcs_pkg::FUNC_PICK, '0, '0, '0, '0, 1'b0, 16'd0);
		add_word(drcs_pkg::FUNC_INSERT, 8'hff, 16'd15, 8'd15, 10'h3ff, 1'b1, 16'hffff);
		add_word(drcs_pkg::FUNC_INSERT, 8'h10, 16'd16, 8'd0, 10'd5, 1'b0, '0);
		add_word(drcs_pkg::FUNC_INSERT, 8'h11, 16'd3, 8'd16, 10'd5, 1'b0, '0);
		add_word(drcs_pkg::FUNC_INSERT, 8'h12, 16'hffff, 8'hff, 10'd5, 1'b1, '0);
		add_word(drcs_pkg::FUNC_INSERT, 8'h00, 16'd0, 8'd0, 10'd0, 1'b0, '0);
		add_word(drcs_pkg::FUNC_INSERT, 8'h01, 16'd7, 8'd2, 10'd9, 1'b1, '0);
		add_word(drcs_pkg::FUNC_INSERT, 8'h02, 16'd7, 8'd3, 10'd10, 1'b0, '0);
		add_word(drcs_pkg::FUNC_INSERT, 8'h03, 16'd7, 8'd4, 10'd11, 1'b1, '0);
		add_word(drcs_pkg::FUNC_PICK, '0, '0, '0, '0, 1'b0, 16'd7);
		add_word(drcs_pkg::FUNC_PICK, '0, '0, '0, '0, 1'b0, 16'd8);
		add_word(drcs_pkg::FUNC_PICK, '0, '0, '0, '0, 1'b0, 16'hffff);
		add_word(drcs_pkg::FUNC_PICK, '0, '0, '0, '0, 1'b0, 16'd0);
		add_word(drcs_pkg::FUNC_PICK, '0, '0, '0, '0, 1'b0, 16'd16);
		add_word(drcs_pkg::FUNC_PICK, 8'hff, 16'hffff, 8'hff, 10'h3ff, 1'b1, 16'd5);
		// zero registers reject every insert
		add_sync();
		add_config(drcs_pkg::CFG_TRACK_LIMIT, 16'd0);
		add_word(drcs_pkg::FUNC_INSERT, 8'h20, 16'd0, 8'd0, 10'd1, 1'b0, '0);
		add_sync();
		add_config(drcs_pkg::CFG_TRACK_LIMIT, 16'd16);
		add_config(drcs_pkg::CFG_SECTORS_PER_TRACK, 16'd0);
		add_word(drcs_pkg::FUNC_INSERT, 8'h21, 16'd0, 8'd0, 10'd1, 1'b0, '0);

		// random traffic over several register settings, extremes included
		add_phase(16, 16, 320);
		add_phase(65535, 255, 320);
		add_phase(1, 1, 200);
		add_phase(0, 16, 40);
		add_phase(4, 255, 320);
		add_phase($urandom_range(1, 65535), $urandom_range(1, 255), 320);
		add_phase(16, 0, 40);
		add_phase($urandom_range(2, 40), $urandom_range(1, 255), 320);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// sample on the falling edge so that every update of the edge has landed
		while (pending_steps.size() != 0 || start || results_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
		if (error_count == 0)
			$display("disk_request_clook_scheduler test passed");
		else
			$display("disk_request_clook_scheduler test failed");
		$finish;
	end

	// driver: command words, register writes only once the block has gone quiet
	always @(posedge clk) begin
		if (arst_n) begin
			start_next = start;
			write_next = 1'b0;
			if (start && !busy) begin
				schedule_word(on_port);
				start_next = 1'b0;
				hold_off = on_port.gap;
			end
			if (!start_next && hold_off > 0) begin
				hold_off--;
			end else if (!start_next && pending_steps.size() != 0) begin
				case (pending_steps[0].kind)
					STEP_WORD: begin
						on_port = pending_steps.pop_front();
						func <= on_port.fn;
						req_tag <= on_port.tag;
						req_track <= on_port.trk;
						req_first_sector <= on_port.first;
						req_sector_count <= on_port.count;
						req_is_write <= on_port.wr;
						head_track <= on_port.head;
						start_next = 1'b1;
					end
					STEP_CFG: begin
						taken = pending_steps.pop_front();
						cfg_index <= taken.reg_index;
						cfg_data <= taken.reg_value;
						write_next = 1'b1;
						if (taken.reg_index == drcs_pkg::CFG_TRACK_LIMIT)
							track_limit_now = taken.reg_value;
						else
							sectors_now = taken.reg_value[7:0];
					end
					default: begin
						// hold until every result is in, then let the block settle
						if (results_due.size() != 0) begin
							quiet_cycles = 0;
						end else if (quiet_cycles < SETTLE) begin
							quiet_cycles++;
						end else begin
							quiet_cycles = 0;
							taken = pending_steps.pop_front();
						end
					end
				endcase
			end
			start <= start_next;
			cfg_we <= write_next;
		end
	end

	// monitor: every result word against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (results_due.size() == 0) begin
				flag_error("result word with no command waiting");
			end else begin
				check_field("status", 16'(status), 16'(results_due[0].status));
				check_field("grant_tag", 16'(grant_tag), 16'(results_due[0].tag));
				check_field("grant_track", grant_track, results_due[0].trk);
				check_field("grant_first_sector", 16'(grant_first_sector),
					16'(results_due[0].first));
				check_field("grant_sector_count", 16'(grant_sector_count),
					16'(results_due[0].count));
				check_field("grant_is_write", 16'(grant_is_write), 16'(results_due[0].wr));
				check_field("occupancy", 16'(occupancy), 16'(results_due[0].occ));
				results_due.delete(0);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("disk_request_clook_scheduler test failed");
			$finish;
		end
	end

endmodule
